// File: design/bsw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsw_pkg: shared types and constants of the broadcast stride walker
// Holds the register map, the configuration bundle and small helpers that
// the register file, the stride builder and the walker all use.
// ----------------------------------------------------------------------------
package bsw_pkg;

    localparam int MAX_LEVELS = 6;
    localparam int NUM_OPS    = 4;
    localparam int SIZE_W     = 32;
    localparam int MASK_W     = 24;
    localparam int FIELD_W    = 48;
    localparam int LVL_W      = 3;
    localparam int OP_W       = 2;
    localparam int PADDR_W    = 5;
    localparam int PDATA_W    = 32;
    localparam int CHUNK_W    = 16;

    // Register indexes (word addresses); sizes occupy indexes zero to five.
    localparam logic [2:0] REG_SIZE_FIRST = 3'd0;
    localparam logic [2:0] REG_SIZE_LAST  = 3'd5;
    localparam logic [2:0] REG_VARY_MASKS = 3'd6;
    localparam logic [2:0] REG_FOUR_OP    = 3'd7;

    // Operand index of the fourth operand, present only in four-operand mode.
    localparam logic [OP_W-1:0] OP_D = 2'd3;

    typedef logic [SIZE_W-1:0] size_t;

    typedef struct packed {
        size_t [MAX_LEVELS-1:0] size;
        logic [MASK_W-1:0]      vary;
        logic                   four_op;
    } cfg_t;

    // Number of loop levels in use: four-operand mode drops the outermost level.
    function automatic logic [LVL_W-1:0] active_levels(input logic four_op,
                                                       input logic [LVL_W-1:0] levels);
        return (four_op && levels > 3'd5) ? 3'd5 : levels;
    endfunction

    // True when the operand varies along the given level.
    function automatic logic vary_bit(input logic [MASK_W-1:0] vary,
                                      input logic [LVL_W-1:0] lvl,
                                      input logic [OP_W-1:0] op);
        return vary[{lvl, op}];
    endfunction

endpackage

// File: design/bsw_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsw_cfg_regs: configuration register file with APB-style access
// Holds the level sizes, the vary masks and the operand mode, and flags each
// completed write so that the stride tables get rebuilt.
// ----------------------------------------------------------------------------
module bsw_cfg_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bsw_pkg::PADDR_W-1:0] paddr,
    input  logic [bsw_pkg::PDATA_W-1:0] pwdata,
    output logic [bsw_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output bsw_pkg::cfg_t               cfg,
    output logic                        wr_strobe
);
    import bsw_pkg::*;

    cfg_t            cfg_reg;
    cfg_t            cfg_next;
    logic            wr_en;
    logic [2:0]      reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel & penable & pwrite;

    // Register update on a completed write transfer.
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            priority if (reg_idx <= REG_SIZE_LAST) begin
                cfg_next.size[reg_idx] = pwdata;
            end else if (reg_idx == REG_VARY_MASKS) begin
                cfg_next.vary = pwdata[MASK_W-1:0];
            end else begin
                cfg_next.four_op = pwdata[0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < MAX_LEVELS; j++) begin
                cfg_reg.size[j] <= SIZE_W'(1);
            end
            cfg_reg.vary    <= '0;
            cfg_reg.four_op <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Read-back mux.
    always_comb begin
        priority if (reg_idx <= REG_SIZE_LAST) begin
            prdata = cfg_reg.size[reg_idx];
        end else if (reg_idx == REG_VARY_MASKS) begin
            prdata = PDATA_W'(cfg_reg.vary);
        end else begin
            prdata = PDATA_W'(cfg_reg.four_op);
        end
    end

    assign cfg       = cfg_reg;
    assign wr_strobe = wr_en;

endmodule

// File: design/bsw_stride_builder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsw_stride_builder: sequencer that derives the per-level offset steps
// For each operand it walks the levels, keeps the running span (product of
// the sizes of the levels the operand varies along) with a 16-bit by 32-bit
// multiplier, one span chunk at a time, and stores prefix sums of the
// per-level strides, so the walker needs one add per operand per element.
// ----------------------------------------------------------------------------
module bsw_stride_builder #(
    parameter int LEVELS      = 6,
    parameter int OFFSET_BITS = 48
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  bsw_pkg::cfg_t         cfg,
    input  logic                  start,
    output logic                  busy,
    output logic [bsw_pkg::NUM_OPS-1:0][LEVELS-1:0][OFFSET_BITS-1:0] delta
);
    import bsw_pkg::*;

    localparam int NCH      = (OFFSET_BITS + CHUNK_W - 1) / CHUNK_W;
    localparam int CW       = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int PP_W     = CHUNK_W + SIZE_W;
    localparam int PP_EXT_W = OFFSET_BITS + PP_W;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_INIT = 4'b0010,
        ST_MUL  = 4'b0100,
        ST_ACC  = 4'b1000
    } bld_state_t;

    bld_state_t              state_reg, state_next;
    logic [OP_W-1:0]         op_reg, op_next;
    logic [LVL_W-1:0]        lvl_reg, lvl_next;
    logic [CW-1:0]           chunk_reg, chunk_next;
    logic [OFFSET_BITS-1:0]  span_reg, span_next;
    logic [OFFSET_BITS-1:0]  prod_reg, prod_next;
    logic [OFFSET_BITS-1:0]  acc_reg, acc_next;
    logic [NUM_OPS-1:0][LEVELS-1:0][OFFSET_BITS-1:0] delta_reg, delta_next;

    logic                    op_on;
    logic [LVL_W-1:0]        nl;
    logic [LVL_W-1:0]        lvl_up;
    size_t                   size_cur;
    logic [OFFSET_BITS-1:0]  span_sh;
    logic [PP_W-1:0]         pp;
    logic [PP_EXT_W-1:0]     pp_ext;
    logic                    cur, nxt, inc0;
    logic [OFFSET_BITS-1:0]  new_span;
    logic [OFFSET_BITS-1:0]  stride;
    logic [OFFSET_BITS-1:0]  acc_sum;
    logic                    stride_on;
    logic                    last_lvl, last_chunk;
    logic                    wr_en;
    logic [LVL_W-1:0]        wr_lvl;
    logic [OFFSET_BITS-1:0]  wr_val;

    // Datapath: one partial product per cycle and the stride for the level.
    // A level of size zero counts as a level of size one.
    always_comb begin
        op_on     = (op_reg != OP_D) || cfg.four_op;
        nl        = active_levels(cfg.four_op, LVL_W'(LEVELS));
        lvl_up    = lvl_reg + 3'd1;
        size_cur  = (cfg.size[lvl_reg] == '0) ? SIZE_W'(1) : cfg.size[lvl_reg];
        span_sh   = span_reg >> {chunk_reg, 4'b0000};
        pp        = PP_W'(span_sh[CHUNK_W-1:0]) * PP_W'(size_cur);
        pp_ext    = PP_EXT_W'(pp) << {chunk_reg, 4'b0000};
        cur       = vary_bit(cfg.vary, lvl_reg, op_reg);
        nxt       = vary_bit(cfg.vary, lvl_up, op_reg);
        inc0      = op_on && vary_bit(cfg.vary, 3'd0, op_reg);
        new_span  = cur ? prod_reg : span_reg;
        stride_on = op_on && (lvl_up < nl);
        priority if (stride_on && nxt && !cur) begin
            stride = new_span;
        end else if (stride_on && cur && !nxt) begin
            stride = OFFSET_BITS'(0) - new_span;
        end else begin
            stride = '0;
        end
        acc_sum    = acc_reg + stride;
        last_lvl   = (lvl_reg == LVL_W'(LEVELS - 2));
        last_chunk = (chunk_reg == CW'(NCH - 1));
    end

    // Sequencer: operands outer, levels inner, chunks of the span innermost.
    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        lvl_next   = lvl_reg;
        chunk_next = chunk_reg;
        span_next  = span_reg;
        prod_next  = prod_reg;
        acc_next   = acc_reg;
        wr_en      = 1'b0;
        wr_lvl     = '0;
        wr_val     = acc_sum;
        unique case (state_reg)
            ST_IDLE: begin
            end
            ST_INIT: begin
                span_next  = OFFSET_BITS'(1);
                acc_next   = OFFSET_BITS'(inc0);
                wr_en      = 1'b1;
                wr_lvl     = '0;
                wr_val     = OFFSET_BITS'(inc0);
                lvl_next   = '0;
                chunk_next = '0;
                prod_next  = '0;
                if (LEVELS > 1) begin
                    state_next = ST_MUL;
                end else if (op_reg == OP_D) begin
                    state_next = ST_IDLE;
                end else begin
                    op_next    = op_reg + 2'd1;
                    state_next = ST_INIT;
                end
            end
            ST_MUL: begin
                prod_next  = prod_reg + pp_ext[OFFSET_BITS-1:0];
                chunk_next = chunk_reg + CW'(1);
                if (last_chunk) begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                span_next = new_span;
                acc_next  = acc_sum;
                wr_en     = 1'b1;
                wr_lvl    = lvl_up;
                wr_val    = acc_sum;
                if (!last_lvl) begin
                    lvl_next   = lvl_up;
                    chunk_next = '0;
                    prod_next  = '0;
                    state_next = ST_MUL;
                end else if (op_reg == OP_D) begin
                    state_next = ST_IDLE;
                end else begin
                    op_next    = op_reg + 2'd1;
                    state_next = ST_INIT;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        // A register write restarts the whole pass.
        if (start) begin
            state_next = ST_INIT;
            op_next    = '0;
        end
    end

    // Table write port.
    always_comb begin
        delta_next = delta_reg;
        for (int i = 0; i < NUM_OPS; i++) begin
            for (int j = 0; j < LEVELS; j++) begin
                if (wr_en && op_reg == OP_W'(i) && wr_lvl == LVL_W'(j)) begin
                    delta_next[i][j] = wr_val;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            op_reg    <= '0;
            lvl_reg   <= '0;
            chunk_reg <= '0;
            delta_reg <= '0;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
            lvl_reg   <= lvl_next;
            chunk_reg <= chunk_next;
            delta_reg <= delta_next;
        end
    end

    always_ff @(posedge aclk) begin
        span_reg <= span_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign busy  = (state_reg != ST_IDLE);
    assign delta = delta_reg;

endmodule

// File: design/bsw_walker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsw_walker: per-element level counters, operand offsets and result register
// Each accepted request loads the result register and, unless it is the final
// element, finds the innermost level that does not wrap and adds the matching
// prefix stride to every active operand offset, all in the same cycle.
// ----------------------------------------------------------------------------
module bsw_walker #(
    parameter int LEVELS      = 6,
    parameter int OFFSET_BITS = 48
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  bsw_pkg::cfg_t                 cfg,
    input  logic [bsw_pkg::NUM_OPS-1:0][LEVELS-1:0][OFFSET_BITS-1:0] delta,
    input  logic                          build_busy,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic                          restart,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bsw_pkg::FIELD_W-1:0]   offset_a,
    output logic [bsw_pkg::FIELD_W-1:0]   offset_b,
    output logic [bsw_pkg::FIELD_W-1:0]   offset_c,
    output logic [bsw_pkg::FIELD_W-1:0]   offset_d,
    output logic [bsw_pkg::FIELD_W-1:0]   result_index,
    output logic                          final_element
);
    import bsw_pkg::*;

    logic [LEVELS-1:0][SIZE_W-1:0]       cnt_reg, cnt_next, cnt_eff;
    logic [NUM_OPS-1:0][OFFSET_BITS-1:0] off_reg, off_next, off_eff, delta_sel;
    logic [OFFSET_BITS-1:0]              oc_reg, oc_next, oc_eff;
    logic                                done_reg, done_next;
    logic                                m_valid_reg;
    logic [FIELD_W-1:0]                  oa_reg, ob_reg, oc_out_reg, od_reg, idx_reg;
    logic                                last_reg;

    logic                                in_fire;
    logic                                fresh;
    logic [LVL_W-1:0]                    nl;
    logic [LEVELS-1:0]                   lvl_last, wrap, first;
    logic [LEVELS:0]                     carry;
    logic                                all_last;
    logic [NUM_OPS-1:0]                  op_on;

    assign s_tready = !build_busy && (!m_valid_reg || m_tready);
    assign in_fire  = s_tvalid && s_tready;

    // Level status: which levels sit at their last value, and the carry chain.
    always_comb begin
        fresh = restart | done_reg;
        nl    = active_levels(cfg.four_op, LVL_W'(LEVELS));
        for (int j = 0; j < LEVELS; j++) begin
            cnt_eff[j]  = fresh ? '0 : cnt_reg[j];
            lvl_last[j] = (LVL_W'(j) >= nl) ||
                          (({1'b0, cnt_eff[j]} + 33'd1) >= {1'b0, cfg.size[j]});
        end
        carry[0] = 1'b1;
        for (int j = 0; j < LEVELS; j++) begin
            wrap[j]      = carry[j] & lvl_last[j];
            first[j]     = carry[j] & ~lvl_last[j];
            carry[j + 1] = wrap[j];
        end
        all_last = carry[LEVELS];
    end

    // Offset step: pick the prefix stride of the level that advances.
    always_comb begin
        for (int i = 0; i < NUM_OPS; i++) begin
            off_eff[i]   = fresh ? '0 : off_reg[i];
            op_on[i]     = (i < NUM_OPS - 1) || cfg.four_op;
            delta_sel[i] = '0;
            for (int j = 0; j < LEVELS; j++) begin
                if (first[j]) begin
                    delta_sel[i] = delta_sel[i] | delta[i][j];
                end
            end
        end
        oc_eff = fresh ? '0 : oc_reg;
    end

    // Next walk state.
    always_comb begin
        cnt_next  = cnt_reg;
        off_next  = off_reg;
        oc_next   = oc_reg;
        done_next = done_reg;
        if (in_fire) begin
            if (all_last) begin
                cnt_next  = cnt_eff;
                off_next  = off_eff;
                oc_next   = oc_eff;
                done_next = 1'b1;
            end else begin
                for (int j = 0; j < LEVELS; j++) begin
                    priority if (wrap[j]) begin
                        cnt_next[j] = '0;
                    end else if (first[j]) begin
                        cnt_next[j] = cnt_eff[j] + SIZE_W'(1);
                    end else begin
                        cnt_next[j] = cnt_eff[j];
                    end
                end
                for (int i = 0; i < NUM_OPS; i++) begin
                    off_next[i] = op_on[i] ? (off_eff[i] + delta_sel[i]) : off_eff[i];
                end
                oc_next   = oc_eff + OFFSET_BITS'(1);
                done_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            off_reg     <= '0;
            oc_reg      <= '0;
            done_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            off_reg  <= off_next;
            oc_reg   <= oc_next;
            done_reg <= done_next;
            if (in_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result register, loaded on every accepted request.
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            oa_reg     <= FIELD_W'(off_eff[0]);
            ob_reg     <= FIELD_W'(off_eff[1]);
            oc_out_reg <= FIELD_W'(off_eff[2]);
            od_reg     <= cfg.four_op ? FIELD_W'(off_eff[3]) : '0;
            idx_reg    <= FIELD_W'(oc_eff);
            last_reg   <= all_last;
        end
    end

    assign m_tvalid      = m_valid_reg;
    assign offset_a      = oa_reg;
    assign offset_b      = ob_reg;
    assign offset_c      = oc_out_reg;
    assign offset_d      = od_reg;
    assign result_index  = idx_reg;
    assign final_element = last_reg;

    // An accepted request always leaves a result waiting.
    a_fire_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> m_valid_reg)
        else $error("accepted request produced no result");

    // The final element closes the walk.
    a_final_done: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && all_last |=> done_reg && final_element)
        else $error("final element did not mark the walk as done");

    // Any other element advances the output index by one.
    a_index_step: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && !all_last |=> oc_reg == $past(oc_eff + OFFSET_BITS'(1)))
        else $error("output index did not advance by one");

endmodule

// File: design/broadcast_stride_walker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// broadcast_stride_walker: address walker for broadcast elementwise ops
// Produces, per request, the offsets of three or four operands, the output
// index and a last-element flag over up to six nested loop levels.
// ----------------------------------------------------------------------------
// The block takes one advance request per cycle while no stride build runs and
// the result stream does not stall, and returns one result per request in the
// cycle after acceptance, through a result register that lets a new request in
// during the cycle in which the previous result is taken. The compare of the
// per-level counters against the level sizes sits between the walk state
// registers and that result register; the single add per operand offset
// updates only the walk state registers. After each configuration write a
// stride builder recomputes the prefix stride tables with one 16-bit by 32-bit
// multiplier; while it runs s_tready is low. Offsets wrap modulo 2^OFFSET_BITS.
// ----------------------------------------------------------------------------
module broadcast_stride_walker #(
    parameter int LEVELS      = 6,
    parameter int OFFSET_BITS = 48
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // Configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bsw_pkg::PADDR_W-1:0] paddr,
    input  logic [bsw_pkg::PDATA_W-1:0] pwdata,
    output logic [bsw_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    // Request stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [0] restart, [7:1] zero
    // Result stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // [47:0] offset_a, [95:48] offset_b, [143:96] offset_c,
    // [191:144] offset_d, [239:192] result_index
    output logic [239:0]                m_tdata,
    output logic                        m_tlast    // final_element
);
    import bsw_pkg::*;

    cfg_t                                  cfg;
    logic                                  wr_strobe;
    logic                                  build_busy;
    logic [NUM_OPS-1:0][LEVELS-1:0][OFFSET_BITS-1:0] delta;
    logic [FIELD_W-1:0]                    offset_a, offset_b, offset_c, offset_d;
    logic [FIELD_W-1:0]                    result_index;

    bsw_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .cfg       (cfg),
        .wr_strobe (wr_strobe)
    );

    bsw_stride_builder #(
        .LEVELS      (LEVELS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_stride_builder (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .start   (wr_strobe),
        .busy    (build_busy),
        .delta   (delta)
    );

    bsw_walker #(
        .LEVELS      (LEVELS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_walker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .delta         (delta),
        .build_busy    (build_busy),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .restart       (s_tdata[0]),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .offset_a      (offset_a),
        .offset_b      (offset_b),
        .offset_c      (offset_c),
        .offset_d      (offset_d),
        .result_index  (result_index),
        .final_element (m_tlast)
    );

    assign m_tdata = {result_index, offset_d, offset_c, offset_b, offset_a};

endmodule
